>>> rtl/core/stack_with_middle_delete_defines.svh
// Assertion macros shared by the stack with middle delete design.
`ifndef STACK_WITH_MIDDLE_DELETE_DEFINES_SVH
`define STACK_WITH_MIDDLE_DELETE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SWMD_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define SWMD_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

>>> rtl/core/swmd_pkg.sv
// Shared types, constants and command codes of the stack with middle delete.
package swmd_pkg;

   localparam int STACK_DEPTH = 16;
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int DEPTH_NOW_W = 5;

   localparam logic [1:0] FN_PUSH = 2'd0;
   localparam logic [1:0] FN_POP  = 2'd1;
   localparam logic [1:0] FN_MID  = 2'd2;
   localparam logic [1:0] FN_DEL  = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic signed [WORD_W-1:0] EMPTY_VALUE = -32'sd1;

   // Read address selection.
   localparam logic [1:0] RD_TOP  = 2'd0;
   localparam logic [1:0] RD_MID  = 2'd1;
   localparam logic [1:0] RD_NEXT = 2'd2;

   // Write address selection.
   localparam logic WR_PUSH  = 1'b0;
   localparam logic WR_SHIFT = 1'b1;

   // Source of the response payload.
   localparam logic [2:0] RK_PUSH  = 3'd0;
   localparam logic [2:0] RK_FULL  = 3'd1;
   localparam logic [2:0] RK_EMPTY = 3'd2;
   localparam logic [2:0] RK_RDATA = 3'd3;
   localparam logic [2:0] RK_HELD  = 3'd4;

   typedef struct packed {
      logic [1:0]               func;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] result_value;
      logic [1:0]               status;
      logic [DEPTH_NOW_W-1:0]   depth_now;
   } rsp_type;

   typedef struct packed {
      logic       accept;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_sel;
      logic       idx_load_mid;
      logic       idx_inc;
      logic       hold_load;
      logic       count_inc;
      logic       count_dec;
      logic       respond;
      logic [2:0] rsp_kind;
   } ctl_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       empty;
      logic       full;
      logic       shift_more;
   } dp_status_type;

endpackage

>>> rtl/core/stack_with_middle_delete.sv
// Top level: 16-word stack with read and delete of the middle word.
// Push and any request on an empty stack respond straight from decode; pop and read middle
// respond after a registered store read; delete middle also moves the k words above the
// middle down one at a time, each by a store read then a store write.
// A new item can be accepted from the cycle its predecessor's result is strobed.
// Synchronous reset empties the stack and clears state and strobe; stored words are kept.
module stack_with_middle_delete (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  swmd_pkg::req_type req_data,
   output logic              rsp_valid,
   output swmd_pkg::rsp_type rsp_data
);
   import swmd_pkg::*;
`include "stack_with_middle_delete_defines.svh"

   ctl_cmd_type   cmd;
   dp_status_type status;

   swmd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   swmd_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   `SWMD_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `SWMD_ASSERT_NOW(a_depth_range, rsp_valid, rsp_data.depth_now <= DEPTH_NOW_W'(STACK_DEPTH), "depth beyond capacity")
   `SWMD_ASSERT_NOW(a_full_depth, rsp_valid && rsp_data.status == ST_FULL, rsp_data.depth_now == DEPTH_NOW_W'(STACK_DEPTH), "full status without full stack")
   `SWMD_ASSERT_NOW(a_empty_rsp, rsp_valid && rsp_data.status == ST_EMPTY, rsp_data.result_value == EMPTY_VALUE && rsp_data.depth_now == '0, "bad empty response")

endmodule

>>> rtl/core/swmd_dpath.sv
// Datapath: element store, count, shift index and response registers.
module swmd_dpath (
   input  logic                    clock,
   input  logic                    reset,
   input  swmd_pkg::req_type       req_data,
   input  swmd_pkg::ctl_cmd_type   cmd,
   output swmd_pkg::dp_status_type status,
   output logic                    rsp_valid,
   output swmd_pkg::rsp_type       rsp_data
);
   import swmd_pkg::*;

   logic signed [WORD_W-1:0] store_ff [STACK_DEPTH];
   logic signed [WORD_W-1:0] rdata_ff;
   logic signed [WORD_W-1:0] held_ff;
   req_type                  req_ff;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         idx_ff;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;

   logic [CNT_W-1:0] top_c, mid_c, next_c;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic signed [WORD_W-1:0] wr_data;

   always_comb begin
      top_c  = count_ff - CNT_W'(1);
      mid_c  = top_c >> 1;
      next_c = CNT_W'(idx_ff) + CNT_W'(1);
      case (cmd.rd_sel)
         RD_TOP:  rd_addr = top_c[IDX_W-1:0];
         RD_MID:  rd_addr = mid_c[IDX_W-1:0];
         RD_NEXT: rd_addr = next_c[IDX_W-1:0];
         default: rd_addr = top_c[IDX_W-1:0];
      endcase
      if (cmd.wr_sel == WR_SHIFT) begin
         wr_addr = idx_ff;
         wr_data = rdata_ff;
      end else begin
         wr_addr = count_ff[IDX_W-1:0];
         wr_data = req_ff.push_value;
      end
   end

   always_comb begin
      status.func       = req_ff.func;
      status.empty      = (count_ff == '0);
      status.full       = (count_ff == CNT_W'(STACK_DEPTH));
      status.shift_more = (next_c < count_ff);
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.count_dec) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in.depth_now = DEPTH_NOW_W'(count_in);
      case (cmd.rsp_kind)
         RK_PUSH: begin
            rsp_in.result_value = req_ff.push_value;
            rsp_in.status       = ST_OK;
         end
         RK_FULL: begin
            rsp_in.result_value = req_ff.push_value;
            rsp_in.status       = ST_FULL;
         end
         RK_EMPTY: begin
            rsp_in.result_value = EMPTY_VALUE;
            rsp_in.status       = ST_EMPTY;
         end
         RK_RDATA: begin
            rsp_in.result_value = rdata_ff;
            rsp_in.status       = ST_OK;
         end
         RK_HELD: begin
            rsp_in.result_value = held_ff;
            rsp_in.status       = ST_OK;
         end
         default: begin
            rsp_in.result_value = held_ff;
            rsp_in.status       = ST_OK;
         end
      endcase
   end

   // Single write port and single registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         req_ff <= req_data;
      end
      if (cmd.idx_load_mid) begin
         idx_ff <= mid_c[IDX_W-1:0];
      end else if (cmd.idx_inc) begin
         idx_ff <= next_c[IDX_W-1:0];
      end
      if (cmd.hold_load) begin
         held_ff <= rdata_ff;
      end
      if (cmd.respond) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.respond;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/core/swmd_ctrl.sv
// Controller state machine that sequences each stack request.
module swmd_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  swmd_pkg::dp_status_type status,
   output logic                    busy,
   output swmd_pkg::ctl_cmd_type   cmd
);
   import swmd_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_RDWAIT = 3'd2;
   localparam logic [2:0] S_SHRD   = 3'd3;
   localparam logic [2:0] S_SHWR   = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = S_DECODE;
            end
         end
         S_DECODE: begin
            if (status.func == FN_PUSH) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
               if (status.full) begin
                  cmd.rsp_kind = RK_FULL;
               end else begin
                  cmd.wr_en     = 1'b1;
                  cmd.wr_sel    = WR_PUSH;
                  cmd.count_inc = 1'b1;
                  cmd.rsp_kind  = RK_PUSH;
               end
            end else if (status.empty) begin
               cmd.respond  = 1'b1;
               cmd.rsp_kind = RK_EMPTY;
               state_in     = S_IDLE;
            end else if (status.func == FN_POP) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_TOP;
               state_in   = S_RDWAIT;
            end else begin
               cmd.rd_en        = 1'b1;
               cmd.rd_sel       = RD_MID;
               cmd.idx_load_mid = 1'b1;
               state_in         = S_RDWAIT;
            end
         end
         S_RDWAIT: begin
            if (status.func == FN_DEL) begin
               cmd.hold_load = 1'b1;
               state_in      = S_SHRD;
            end else begin
               cmd.respond   = 1'b1;
               cmd.rsp_kind  = RK_RDATA;
               cmd.count_dec = (status.func == FN_POP);
               state_in      = S_IDLE;
            end
         end
         S_SHRD: begin
            // Move the word above the gap down, one word per read/write pair.
            if (status.shift_more) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = S_SHWR;
            end else begin
               cmd.count_dec = 1'b1;
               cmd.respond   = 1'b1;
               cmd.rsp_kind  = RK_HELD;
               state_in      = S_IDLE;
            end
         end
         S_SHWR: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_SHIFT;
            cmd.idx_inc = 1'b1;
            state_in    = S_SHRD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule
